@@ sv/ccsp_pkg.sv @@
// Package for the CSS color string parser: shared types, character codes,
// the named color tables and elaboration-time helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccsp_pkg;

  localparam int unsigned FractionDigitsDefault = 4;

  // Named color table geometry
  localparam int unsigned NameCount  = 27;
  localparam int unsigned NameMaxLen = 11;
  localparam int unsigned NameIdxW   = 5;
  localparam logic [NameIdxW-1:0] NameNone = 5'd31;

  localparam logic [31:0] OpaqueBlack = 32'hFF00_0000;

  // Character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChClose  = 8'h29;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerG = 8'h67;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  // Component slots of the rgb() list
  localparam logic [2:0] CompRed    = 3'd0;
  localparam logic [2:0] CompGreen  = 3'd1;
  localparam logic [2:0] CompBlue   = 3'd2;
  localparam logic [2:0] CompAlpha  = 3'd3;
  localparam logic [2:0] CompMax    = 3'd7;
  localparam logic [2:0] LimitRgb   = 3'd3;
  localparam logic [2:0] LimitRgba  = 3'd4;

  // Parser modes, one-hot
  typedef enum logic [7:0] {
    MODE_SKIP      = 8'b0000_0001,
    MODE_HEX       = 8'b0000_0010,
    MODE_WORD      = 8'b0000_0100,
    MODE_NAME      = 8'b0000_1000,
    MODE_RGB_AFTER = 8'b0001_0000,
    MODE_RGB_BODY  = 8'b0010_0000,
    MODE_RGB_DONE  = 8'b0100_0000,
    MODE_HEX_DONE  = 8'b1000_0000
  } ccsp_mode_e;

  // Color before alpha scaling; alpha_frac selects the scaled fraction
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       alpha_frac;
  } ccsp_mid_t;

  localparam ccsp_mid_t MidBlack = '{alpha: 8'hFF, red: 8'h00, green: 8'h00,
                                     blue: 8'h00, alpha_frac: 1'b0};

  // Names, right-justified in the vector
  localparam logic [8*NameMaxLen-1:0] NameText [NameCount] = '{
    "black", "white", "red", "green", "blue", "yellow", "cyan", "magenta",
    "orange", "purple", "pink", "gray", "grey", "silver", "maroon", "olive",
    "lime", "aqua", "teal", "navy", "fuchsia", "brown", "darkgray",
    "darkgrey", "lightgray", "lightgrey", "transparent"
  };

  localparam logic [3:0] NameLen [NameCount] = '{
    4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7, 4'd6, 4'd6, 4'd4, 4'd4,
    4'd4, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd5, 4'd8, 4'd8,
    4'd9, 4'd9, 4'd11
  };

  localparam logic [31:0] NameValue [NameCount] = '{
    32'hFF000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'hFF008000, 32'hFF0000FF,
    32'hFFFFFF00, 32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFFA500, 32'hFF800080,
    32'hFFFFC0CB, 32'hFF808080, 32'hFF808080, 32'hFFC0C0C0, 32'hFF800000,
    32'hFF808000, 32'hFF00FF00, 32'hFF00FFFF, 32'hFF008080, 32'hFF000080,
    32'hFFFF00FF, 32'hFFA52A2A, 32'hFFA9A9A9, 32'hFFA9A9A9, 32'hFFD3D3D3,
    32'hFFD3D3D3, 32'h00000000
  };

  // Elaboration only: 10 to the power e
  function automatic int unsigned pow10(input int unsigned e);
    int unsigned r;
    r = 1;
    for (int unsigned k = 0; k < e; k++) r = r * 10;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/ccsp_in_if.sv @@
// Input channel of the CSS color string parser: one character per item.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ccsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;

  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

`default_nettype wire

@@ sv/ccsp_out_if.sv @@
// Output channel of the CSS color string parser: one ARGB word per item.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ccsp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_color;

  modport source (output valid, output argb_color, input ready);
  modport sink   (input valid, input argb_color, output ready);
endinterface

`default_nettype wire

@@ sv/ccsp_name_match.sv @@
// Named color matcher: one candidate lane per name, advanced one character
// per step. Depends on ccsp_pkg for the name tables.
`timescale 1ns / 1ps
`default_nettype none

module ccsp_name_match (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        restart_i,
  input  wire logic [7:0]  char_i,
  output logic      [31:0] argb_o
);
  import ccsp_pkg::*;

  logic [NameCount-1:0] cand_q, cand_d;
  logic [3:0]           pos_q, pos_d;
  logic [NameIdxW-1:0]  win_q, win_d;

  logic [7:0] lc;
  logic       is_letter;
  logic       found;

  function automatic logic [7:0] name_char(input logic [NameIdxW-1:0] idx,
                                           input logic [3:0] pos);
    logic [8*NameMaxLen-1:0] text;
    logic [3:0]              len;
    int unsigned             sh;
    text = NameText[idx];
    len  = NameLen[idx];
    sh   = 0;
    if (pos < len) sh = 8 * (int'(len) - 1 - int'(pos));
    return (pos < len) ? text[sh +: 8] : ChNul;
  endfunction

  assign is_letter = (char_i >= ChUpperA && char_i <= ChUpperZ) ||
                     (char_i >= ChLowerA && char_i <= ChLowerZ);
  assign lc = (char_i >= ChUpperA && char_i <= ChUpperZ) ? (char_i | 8'h20) : char_i;

  // Lane update; the first finished lane followed by a non-letter wins
  always_comb begin
    cand_d = cand_q;
    pos_d  = pos_q;
    win_d  = win_q;
    found  = 1'b0;
    if (step_i && win_q == NameNone) begin
      for (int i = 0; i < NameCount; i++) begin
        if (cand_q[i]) begin
          if (pos_q < NameLen[i]) begin
            if (lc != name_char(NameIdxW'(i), pos_q)) cand_d[i] = 1'b0;
          end else begin
            cand_d[i] = 1'b0;
            if (!is_letter && !found) begin
              win_d = NameIdxW'(i);
              found = 1'b1;
            end
          end
        end
      end
      if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
    end
  end

  // Color for the string ending now: winner, else a lane ending here
  always_comb begin
    argb_o = OpaqueBlack;
    if (win_d != NameNone) begin
      argb_o = NameValue[win_d];
    end else begin
      for (int i = NameCount - 1; i >= 0; i--) begin
        if (cand_d[i] && NameLen[i] == pos_d) argb_o = NameValue[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '1;
      pos_q  <= '0;
      win_q  <= NameNone;
    end else if (restart_i) begin
      cand_q <= '1;
      pos_q  <= '0;
      win_q  <= NameNone;
    end else begin
      cand_q <= cand_d;
      pos_q  <= pos_d;
      win_q  <= win_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ccsp_parse.sv @@
// Per-character parser: mode, hex run, rgb() component state, and the
// registered pre-alpha result. Depends on ccsp_pkg and ccsp_name_match.
`timescale 1ns / 1ps
`default_nettype none

module ccsp_parse #(
  parameter int unsigned FRACTION_DIGITS = ccsp_pkg::FractionDigitsDefault,
  localparam int unsigned FracW = $clog2(ccsp_pkg::pow10(FRACTION_DIGITS))
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_valid_i,
  output logic                       step_ready_o,
  input  wire logic [7:0]            char_i,
  input  wire logic                  last_i,
  output logic                       mid_valid_o,
  input  wire logic                  mid_ready_i,
  output ccsp_pkg::ccsp_mid_t        mid_o,
  output logic      [FracW-1:0]      mid_num_o
);
  import ccsp_pkg::*;

  localparam int unsigned FcW   = $clog2(FRACTION_DIGITS + 1);
  localparam int unsigned ProdW = FracW + 4;

  localparam ccsp_mid_t StoreReset = '{alpha: 8'hFF, red: 8'h00, green: 8'h00,
                                       blue: 8'h00, alpha_frac: 1'b0};

  ccsp_mode_e       mode_q, mode_d;
  logic [31:0]      hex_q, hex_d;
  logic [3:0]       hcnt_q, hcnt_d;
  logic [1:0]       pp_q, pp_d;
  logic             aform_q, aform_d;
  logic [2:0]       ci_q, ci_d;
  logic             nf_in_q, nf_in_d;
  logic             nf_frac_q, nf_frac_d;
  logic [8:0]       ip_q, ip_d;
  logic [FracW-1:0] fn_q, fn_d;
  logic [FcW-1:0]   fc_q, fc_d;
  ccsp_mid_t        store_q, store_d;
  logic [FracW-1:0] anum_q, anum_d;
  logic             term_q, term_d;

  logic             mid_valid_q;
  ccsp_mid_t        mid_q;
  logic [FracW-1:0] mid_num_q;

  logic             fire, act, restart, mid_can;
  logic             word, body, dispatch, name_step;
  logic             is_dig, is_space, hex_ok;
  logic [3:0]       digit, hex_val;
  logic [11:0]      ip_mul;
  logic [ProdW-1:0] frac_prod;
  logic [2:0]       ci_inc, ci_f;
  logic [31:0]      name_argb;
  ccsp_mid_t        fin, result;
  logic [FracW-1:0] fin_num;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    return (v > 9'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [2:0] comp_inc(input logic [2:0] ci);
    return (ci != CompMax) ? ci + 3'd1 : ci;
  endfunction

  function automatic logic [2:0] comp_limit(input logic af);
    return af ? LimitRgba : LimitRgb;
  endfunction

  // Closes one number into its component slot
  function automatic ccsp_mid_t finish_store(input ccsp_mid_t st, input logic [2:0] ci,
                                             input logic [8:0] ip, input logic frac_zero);
    ccsp_mid_t r;
    r = st;
    case (ci)
      CompRed:   r.red   = sat8(ip);
      CompGreen: r.green = sat8(ip);
      CompBlue:  r.blue  = sat8(ip);
      CompAlpha: begin
        if (ip == 9'd0) begin
          r.alpha_frac = 1'b1;
        end else if (ip == 9'd1 && frac_zero) begin
          r.alpha      = 8'hFF;
          r.alpha_frac = 1'b0;
        end else begin
          r.alpha      = sat8(ip);
          r.alpha_frac = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Weight of the fraction digit at position pos, in units of the last digit
  function automatic logic [FracW-1:0] frac_weight(input logic [FcW-1:0] pos);
    logic [FracW-1:0] w;
    int unsigned      p;
    w = '0;
    p = 1;
    for (int k = FRACTION_DIGITS - 1; k >= 0; k--) begin
      if (pos == FcW'(k)) w = FracW'(p);
      p = p * 10;
    end
    return w;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = ChLowerR;
      2'd1:    ch = ChLowerG;
      2'd2:    ch = ChLowerB;
      default: ch = ChNul;
    endcase
    return ch;
  endfunction

  // Handshake toward the input register and the mid register
  assign mid_can      = !mid_valid_q || mid_ready_i;
  assign step_ready_o = !last_i || mid_can;
  assign fire         = step_valid_i && step_ready_o;
  assign restart      = fire && last_i;
  assign act          = fire && !term_q && (char_i != ChNul);

  // Character classes
  assign is_dig   = (char_i >= ChDigit0) && (char_i <= ChDigit9);
  assign is_space = (char_i == ChSpace) || (char_i >= ChTab && char_i <= ChCr);
  assign digit    = 4'(char_i - ChDigit0);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (is_dig) begin
      hex_val = digit;
    end else if (char_i >= ChLowerA && char_i <= ChLowerF) begin
      hex_val = 4'(char_i - ChLowerA + 8'd10);
    end else if (char_i >= ChUpperA && char_i <= ChUpperF) begin
      hex_val = 4'(char_i - ChUpperA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign ip_mul    = ({3'b0, ip_q} << 3) + ({3'b0, ip_q} << 1) + {8'b0, digit};
  assign frac_prod = ProdW'(digit) * ProdW'(frac_weight(fc_q));
  assign ci_inc    = comp_inc(ci_q);

  // Next state for one character
  always_comb begin
    mode_d    = mode_q;
    hex_d     = hex_q;
    hcnt_d    = hcnt_q;
    pp_d      = pp_q;
    aform_d   = aform_q;
    ci_d      = ci_q;
    nf_in_d   = nf_in_q;
    nf_frac_d = nf_frac_q;
    ip_d      = ip_q;
    fn_d      = fn_q;
    fc_d      = fc_q;
    store_d   = store_q;
    anum_d    = anum_q;
    term_d    = term_q;
    word      = 1'b0;
    body      = 1'b0;
    dispatch  = 1'b0;

    if (fire && !term_q && char_i == ChNul) term_d = 1'b1;

    if (act) begin
      case (mode_q)
        MODE_SKIP: begin
          if (is_space) begin
            mode_d = MODE_SKIP;
          end else if (char_i == ChHash) begin
            mode_d = MODE_HEX;
          end else begin
            word = 1'b1;
          end
        end
        MODE_WORD: word = 1'b1;
        MODE_HEX: begin
          if (!hex_ok) begin
            mode_d = MODE_HEX_DONE;
          end else begin
            if (hcnt_q < 4'd8) hex_d = {hex_q[27:0], hex_val};
            if (hcnt_q < 4'd9) hcnt_d = hcnt_q + 4'd1;
          end
        end
        MODE_RGB_AFTER: begin
          mode_d = MODE_RGB_BODY;
          if (char_i == ChLowerA) aform_d = 1'b1;
          else body = 1'b1;
        end
        MODE_RGB_BODY: body = 1'b1;
        default: ;
      endcase
    end

    // "rgb" prefix tracking while the word is still undecided
    if (word) begin
      if (char_i == prefix_char(pp_q)) begin
        if (pp_q == 2'd2) begin
          pp_d   = 2'd0;
          mode_d = MODE_RGB_AFTER;
        end else begin
          pp_d   = pp_q + 2'd1;
          mode_d = MODE_WORD;
        end
      end else begin
        mode_d = MODE_NAME;
      end
    end

    // Component list body
    if (body) begin
      dispatch = 1'b1;
      if (nf_in_q) begin
        if (is_dig) begin
          dispatch = 1'b0;
          if (nf_frac_q) begin
            if (fc_q < FcW'(FRACTION_DIGITS)) begin
              fn_d = fn_q + FracW'(frac_prod);
              fc_d = fc_q + FcW'(1);
            end
          end else begin
            ip_d = (ip_mul > 12'd256) ? 9'd256 : ip_mul[8:0];
          end
        end else if (char_i == ChDot && !nf_frac_q) begin
          dispatch  = 1'b0;
          nf_frac_d = 1'b1;
        end else begin
          store_d = finish_store(store_q, ci_q, ip_q, fn_q == '0);
          if (ci_q == CompAlpha && ip_q == 9'd0) anum_d = fn_q;
          ci_d      = ci_inc;
          nf_in_d   = 1'b0;
          nf_frac_d = 1'b0;
          ip_d      = '0;
          fn_d      = '0;
          fc_d      = '0;
          if (ci_inc >= comp_limit(aform_q)) begin
            dispatch = 1'b0;
            mode_d   = MODE_RGB_DONE;
          end
        end
      end
      if (dispatch) begin
        if (char_i == ChClose) begin
          mode_d = MODE_RGB_DONE;
        end else if (is_dig) begin
          nf_in_d   = 1'b1;
          nf_frac_d = 1'b0;
          ip_d      = {5'b0, digit};
        end else if (char_i == ChDot) begin
          nf_in_d   = 1'b1;
          nf_frac_d = 1'b1;
        end
      end
    end
  end

  assign name_step = act && (word || mode_q == MODE_NAME);

  ccsp_name_match u_name (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (name_step),
    .restart_i (restart),
    .char_i    (char_i),
    .argb_o    (name_argb)
  );

  // rgb() result with an open number closed and a missing alpha zeroed
  always_comb begin
    fin     = store_d;
    fin_num = anum_d;
    ci_f    = ci_d;
    if (nf_in_d) begin
      fin = finish_store(store_d, ci_d, ip_d, fn_d == '0);
      if (ci_d == CompAlpha && ip_d == 9'd0) fin_num = fn_d;
      ci_f = comp_inc(ci_d);
    end
    if (aform_d && ci_f < comp_limit(aform_d)) begin
      fin.alpha      = 8'h00;
      fin.alpha_frac = 1'b0;
    end
  end

  // Result for a string ending on this character
  always_comb begin
    result = MidBlack;
    case (mode_d)
      MODE_HEX, MODE_HEX_DONE: begin
        if (hcnt_d == 4'd3) begin
          result.red   = {hex_d[11:8], hex_d[11:8]};
          result.green = {hex_d[7:4], hex_d[7:4]};
          result.blue  = {hex_d[3:0], hex_d[3:0]};
        end else if (hcnt_d == 4'd6) begin
          {result.red, result.green, result.blue} = hex_d[23:0];
        end else if (hcnt_d == 4'd8) begin
          result.alpha = hex_d[7:0];
          {result.red, result.green, result.blue} = hex_d[31:8];
        end
      end
      MODE_WORD, MODE_NAME: begin
        {result.alpha, result.red, result.green, result.blue} = name_argb;
      end
      MODE_RGB_AFTER, MODE_RGB_BODY: result = fin;
      MODE_RGB_DONE: result = store_d;
      default: result = MidBlack;
    endcase
  end

  // Parser state; a final character returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SKIP;
      hex_q     <= '0;
      hcnt_q    <= '0;
      pp_q      <= '0;
      aform_q   <= 1'b0;
      ci_q      <= CompRed;
      nf_in_q   <= 1'b0;
      nf_frac_q <= 1'b0;
      ip_q      <= '0;
      fn_q      <= '0;
      fc_q      <= '0;
      store_q   <= StoreReset;
      anum_q    <= '0;
      term_q    <= 1'b0;
    end else if (restart) begin
      mode_q    <= MODE_SKIP;
      hex_q     <= '0;
      hcnt_q    <= '0;
      pp_q      <= '0;
      aform_q   <= 1'b0;
      ci_q      <= CompRed;
      nf_in_q   <= 1'b0;
      nf_frac_q <= 1'b0;
      ip_q      <= '0;
      fn_q      <= '0;
      fc_q      <= '0;
      store_q   <= StoreReset;
      anum_q    <= '0;
      term_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      hex_q     <= hex_d;
      hcnt_q    <= hcnt_d;
      pp_q      <= pp_d;
      aform_q   <= aform_d;
      ci_q      <= ci_d;
      nf_in_q   <= nf_in_d;
      nf_frac_q <= nf_frac_d;
      ip_q      <= ip_d;
      fn_q      <= fn_d;
      fc_q      <= fc_d;
      store_q   <= store_d;
      anum_q    <= anum_d;
      term_q    <= term_d;
    end
  end

  // Mid register: valid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (restart) begin
      mid_valid_q <= 1'b1;
    end else if (mid_ready_i) begin
      mid_valid_q <= 1'b0;
    end
  end

  // Mid register: payload
  always_ff @(posedge clk_i) begin
    if (restart) begin
      mid_q     <= result;
      mid_num_q <= fin_num;
    end
  end

  assign mid_valid_o = mid_valid_q;
  assign mid_o       = mid_q;
  assign mid_num_o   = mid_num_q;

endmodule

`default_nettype wire

@@ sv/ccsp_alpha_scale.sv @@
// Output stage: scales a fractional alpha by 255 with a reciprocal multiply
// and holds the finished ARGB word. Depends on ccsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccsp_alpha_scale #(
  parameter int unsigned FRACTION_DIGITS = ccsp_pkg::FractionDigitsDefault,
  localparam int unsigned FracW = $clog2(ccsp_pkg::pow10(FRACTION_DIGITS))
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 mid_valid_i,
  output logic                      mid_ready_o,
  input  wire ccsp_pkg::ccsp_mid_t  mid_i,
  input  wire logic [FracW-1:0]     mid_num_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [31:0]          argb_o
);
  import ccsp_pkg::*;

  // floor(x / 10^FD) as (x * Recip) >> Shift, exact for every x below 2^XW
  localparam int unsigned FracMax = pow10(FRACTION_DIGITS);
  localparam int unsigned XW      = $clog2(255 * FracMax);
  localparam int unsigned Shift   = XW + FracW;
  localparam int unsigned RecipW  = XW + 1;
  localparam int unsigned ProdW   = XW + RecipW;
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(FracMax) - 64'd1) / 64'(FracMax);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  logic             out_valid_q;
  logic [31:0]      argb_q;
  logic             load;
  logic [XW-1:0]    x;
  logic [ProdW-1:0] prod;
  logic [7:0]       alpha;

  assign mid_ready_o = !out_valid_q || out_ready_i;
  assign load        = mid_valid_i && mid_ready_o;

  // 255 * n as a shift and subtract, then the reciprocal multiply
  assign x     = (XW'(mid_num_i) << 8) - XW'(mid_num_i);
  assign prod  = ProdW'(x) * ProdW'(Recip);
  assign alpha = mid_i.alpha_frac ? prod[Shift +: 8] : mid_i.alpha;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) argb_q <= {alpha, mid_i.red, mid_i.green, mid_i.blue};
  end

  assign out_valid_o = out_valid_q;
  assign argb_o      = argb_q;

endmodule

`default_nettype wire

@@ sv/css_color_string_parser.sv @@
// Top level of the CSS color string parser: input register, parser and
// output stage. Depends on ccsp_pkg, the channel interfaces and submodules.
`timescale 1ns / 1ps
`default_nettype none

// One character enters per item at one item per clock, and any item without
// the last-character flag leaves the input register in the very next cycle.
// A final character is turned into its ARGB word in the parser stage, which
// evaluates the whole per-character state update (mode, hex run, rgb()
// number, 27 name lanes) combinationally, and the word passes from the input
// register through the parser result register into the output register; the
// output stage scales a fractional alpha by 255 with one reciprocal
// multiply. Input ready drops only while a final character waits behind a
// full parser result register and a stalled output. FRACTION_DIGITS (1 to
// 6) sets how many alpha fraction digits count; later ones are dropped.
// There is no configuration and no clearing pass after reset.
module css_color_string_parser #(
  parameter int unsigned FRACTION_DIGITS = ccsp_pkg::FractionDigitsDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ccsp_in_if.sink    in_i,
  ccsp_out_if.source out_o
);
  import ccsp_pkg::*;

  localparam int unsigned FracW = $clog2(pow10(FRACTION_DIGITS));

  logic             in_valid_q;
  logic [7:0]       in_char_q;
  logic             in_last_q;
  logic             step_ready, in_take, step_fire;

  logic             mid_valid, mid_ready;
  ccsp_mid_t        mid;
  logic [FracW-1:0] mid_num;

  // Input register
  assign in_i.ready = !in_valid_q || step_ready;
  assign in_take    = in_i.valid && in_i.ready;
  assign step_fire  = in_valid_q && step_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= in_i.char_byte;
      in_last_q <= in_i.last_char;
    end
  end

  ccsp_parse #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (in_valid_q),
    .step_ready_o (step_ready),
    .char_i       (in_char_q),
    .last_i       (in_last_q),
    .mid_valid_o  (mid_valid),
    .mid_ready_i  (mid_ready),
    .mid_o        (mid),
    .mid_num_o    (mid_num)
  );

  ccsp_alpha_scale #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .mid_num_i   (mid_num),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .argb_o      (out_o.argb_color)
  );

endmodule

`default_nettype wire

@@ sv/ccsp_checker.sv @@
// Port-level checks for the CSS color string parser, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module ccsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_last_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_argb_i
);

  // A pending result is not withdrawn while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_argb_i))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled output");

  // A character that is not the last never blocks the next one
  a_mid_char_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("input stalled after a non-final character");

endmodule

bind css_color_string_parser ccsp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_char),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_argb_i  (out_o.argb_color)
);

`default_nettype wire

@@ sim/css_color_string_parser_tb.sv @@
// Self-checking testbench for css_color_string_parser: a short table of color strings, then
// random hex, rgb()/rgba(), named and noise strings, checked against a behavioral predictor.
// Depends on ccsp_pkg, ccsp_in_if, ccsp_out_if and the parser RTL.
`timescale 1ns / 1ps

module css_color_string_parser_tb;
  import ccsp_pkg::*;

  localparam int unsigned FracDigits  = FractionDigitsDefault;
  localparam int          NumNames    = 27;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomChars = 360;
  localparam int unsigned TenPow [7] = '{1, 10, 100, 1000, 10000, 100000, 1000000};

  typedef struct {
    string       text;
    int          nul_at;  // position of an embedded zero byte, -1 for none
    bit          known;   // argb below is the expected color
    logic [31:0] argb;
  } color_case_t;

  localparam int NumDirected = 25;

  color_case_t directed_cases [NumDirected] = '{
    '{"",                     0, 1, 32'hFF000000},
    '{"\011\012\013\014\015 ", -1, 1, 32'hFF000000},
    '{"#fff",                -1, 1, 32'hFFFFFFFF},
    '{"#12aBcD",             -1, 1, 32'hFF12ABCD},
    '{"#11223344",           -1, 1, 32'h44112233},
    '{"#12345",              -1, 1, 32'hFF000000},
    '{"#123456789",          -1, 1, 32'hFF000000},
    '{"#abc xyz",            -1, 1, 32'hFFAABBCC},
    '{"rgb(255,0,128)",      -1, 1, 32'hFFFF0080},
    '{"rgb(999,256,300)",    -1, 1, 32'hFFFFFFFF},
    '{"rgba(10,20,30,0.5)",  -1, 0, 32'h0},
    '{"rgba(1,2,3,1)",       -1, 1, 32'hFF010203},
    '{"rgba(0,0,0,0)",       -1, 1, 32'h00000000},
    '{"rgba(1,2,3,0.123456)", -1, 0, 32'h0},
    '{"rgba(1,2,3",          -1, 1, 32'h00010203},
    '{"rgba(5,6)",           -1, 0, 32'h0},
    '{"rgb(1.9.5,7) tail",   -1, 0, 32'h0},
    '{"rgba(0,0,0,.25)",     -1, 0, 32'h0},
    '{"RGB(1,2,3)",          -1, 1, 32'hFF000000},
    '{"  Orange",            -1, 1, 32'hFFFFA500},
    '{"TRANSPARENT",         -1, 1, 32'h00000000},
    '{"reddish",             -1, 1, 32'hFF000000},
    '{"red;",                -1, 1, 32'hFFFF0000},
    '{"green",                2, 1, 32'hFF000000},
    '{"\200\377",            -1, 1, 32'hFF000000}
  };

  string color_names [NumNames] = '{
    "black", "white", "red", "green", "blue", "yellow", "cyan", "magenta",
    "orange", "purple", "pink", "gray", "grey", "silver", "maroon", "olive",
    "lime", "aqua", "teal", "navy", "fuchsia", "brown", "darkgray",
    "darkgrey", "lightgray", "lightgrey", "transparent"
  };

  logic [31:0] color_argb [NumNames] = '{
    32'hFF000000, 32'hFFFFFFFF, 32'hFFFF0000, 32'hFF008000, 32'hFF0000FF,
    32'hFFFFFF00, 32'hFF00FFFF, 32'hFFFF00FF, 32'hFFFFA500, 32'hFF800080,
    32'hFFFFC0CB, 32'hFF808080, 32'hFF808080, 32'hFFC0C0C0, 32'hFF800000,
    32'hFF808000, 32'hFF00FF00, 32'hFF00FFFF, 32'hFF008080, 32'hFF000080,
    32'hFFFF00FF, 32'hFFA52A2A, 32'hFFA9A9A9, 32'hFFA9A9A9, 32'hFFD3D3D3,
    32'hFFD3D3D3, 32'h00000000
  };

  logic [7:0] rgb_prefix [3] = '{ChLowerR, ChLowerG, ChLowerB};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ccsp_in_if  in_ch ();
  ccsp_out_if out_ch ();

  css_color_string_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk = ~clk;

  // Predictor state, one string at a time
  ccsp_mode_e        pmode;
  logic [31:0]       hex_acc;
  int unsigned       hex_len;
  int unsigned       rgb_match;
  bit                with_alpha;
  int unsigned       slot;
  bit                num_open;
  bit                num_frac;
  int unsigned       whole_part;
  int unsigned       frac_part;
  int unsigned       frac_len;
  logic [7:0]        chan [4];
  logic [NumNames-1:0] alive;
  int unsigned       name_seen;
  int                winner;
  bit                string_ended;

  logic [31:0] expected_colors [$];
  logic [32:0] known_colors [$];   // per string: bit 32 set when the table gives the color
  logic [7:0]  char_buf [$];

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned chars_sent    = 0;
  int unsigned strings_done  = 0;
  int unsigned colors_seen   = 0;
  int unsigned holds_done    = 0;
  int unsigned random_chars  = 0;
  bit          quiet         = 1'b0;
  bit          hold_req      = 1'b0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChDigit0 && c <= ChDigit9;
  endfunction

  function void clear_parser();
    pmode        = MODE_SKIP;
    hex_acc      = '0;
    hex_len      = 0;
    rgb_match    = 0;
    with_alpha   = 1'b0;
    slot         = 0;
    num_open     = 1'b0;
    num_frac     = 1'b0;
    whole_part   = 0;
    frac_part    = 0;
    frac_len     = 0;
    chan[CompRed]   = 8'h00;
    chan[CompGreen] = 8'h00;
    chan[CompBlue]  = 8'h00;
    chan[CompAlpha] = 8'hFF;
    alive        = '1;
    name_seen    = 0;
    winner       = -1;
    string_ended = 1'b0;
  endfunction

  // Narrow the name candidates by one character; a name wins when a non-letter follows it
  function void track_names(logic [7:0] c);
    logic [7:0] lc;
    lc = (c >= ChUpperA && c <= ChUpperZ) ? c + 8'd32 : c;
    if (winner >= 0) return;
    for (int i = 0; i < NumNames; i++) begin
      if (!alive[i]) continue;
      if (name_seen < color_names[i].len()) begin
        if (lc != color_names[i][name_seen]) alive[i] = 1'b0;
      end else begin
        alive[i] = 1'b0;
        if (!((c >= ChLowerA && c <= ChLowerZ) || (c >= ChUpperA && c <= ChUpperZ)) &&
            winner < 0)
          winner = i;
      end
    end
    if (name_seen < 15) name_seen++;
  endfunction

  // Store the number just read into its component slot
  function void close_number();
    if (slot < CompAlpha) begin
      chan[slot] = (whole_part > 255) ? 8'd255 : 8'(whole_part);
    end else if (slot == CompAlpha) begin
      if (whole_part == 0)
        chan[CompAlpha] = 8'((255 * frac_part) / TenPow[frac_len]);
      else if (whole_part == 1 && frac_part == 0)
        chan[CompAlpha] = 8'd255;
      else
        chan[CompAlpha] = (whole_part > 255) ? 8'd255 : 8'(whole_part);
    end
    if (slot < CompMax) slot++;
    num_open   = 1'b0;
    num_frac   = 1'b0;
    whole_part = 0;
    frac_part  = 0;
    frac_len   = 0;
  endfunction

  // One character of the rgb() component list
  function void rgb_body(logic [7:0] c);
    if (num_open) begin
      if (is_digit(c)) begin
        if (num_frac) begin
          if (frac_len < FracDigits) begin
            frac_part = frac_part * 10 + (c - ChDigit0);
            frac_len++;
          end
        end else begin
          whole_part = whole_part * 10 + (c - ChDigit0);
          if (whole_part > 256) whole_part = 256;
        end
        return;
      end
      if (c == ChDot && !num_frac) begin
        num_frac = 1'b1;
        return;
      end
      close_number();
      if (slot >= (with_alpha ? LimitRgba : LimitRgb)) begin
        pmode = MODE_RGB_DONE;
        return;
      end
    end
    if (c == ChClose) begin
      pmode = MODE_RGB_DONE;
    end else if (is_digit(c)) begin
      num_open   = 1'b1;
      whole_part = c - ChDigit0;
    end else if (c == ChDot) begin
      num_open = 1'b1;
      num_frac = 1'b1;
    end
  endfunction

  function void parse_char(logic [7:0] c);
    int h;
    case (pmode)
      MODE_SKIP, MODE_WORD: begin
        if (pmode == MODE_SKIP && (c == ChSpace || (c >= ChTab && c <= ChCr))) return;
        if (pmode == MODE_SKIP && c == ChHash) begin
          pmode = MODE_HEX;
          return;
        end
        pmode = MODE_WORD;
        track_names(c);
        if (c == rgb_prefix[rgb_match]) begin
          rgb_match++;
          if (rgb_match >= 3) begin
            rgb_match = 0;
            pmode     = MODE_RGB_AFTER;
          end
        end else begin
          pmode = MODE_NAME;
        end
      end
      MODE_NAME: track_names(c);
      MODE_HEX: begin
        if (is_digit(c)) h = c - ChDigit0;
        else if (c >= ChLowerA && c <= ChLowerF) h = c - ChLowerA + 10;
        else if (c >= ChUpperA && c <= ChUpperF) h = c - ChUpperA + 10;
        else h = -1;
        if (h < 0) begin
          pmode = MODE_HEX_DONE;
        end else begin
          if (hex_len < 8) hex_acc = {hex_acc[27:0], 4'(h)};
          if (hex_len < 9) hex_len++;
        end
      end
      MODE_RGB_AFTER: begin
        pmode = MODE_RGB_BODY;
        if (c == ChLowerA) with_alpha = 1'b1;
        else rgb_body(c);
      end
      MODE_RGB_BODY: rgb_body(c);
      default: ;
    endcase
  endfunction

  // Color of the string read so far, taken on its final character
  function logic [31:0] color_of_string();
    case (pmode)
      MODE_HEX, MODE_HEX_DONE: begin
        case (hex_len)
          3: return {8'hFF, hex_acc[11:8] * 8'd17, hex_acc[7:4] * 8'd17,
                     hex_acc[3:0] * 8'd17};
          6: return OpaqueBlack | {8'h00, hex_acc[23:0]};
          8: return {hex_acc[7:0], hex_acc[31:8]};
          default: return OpaqueBlack;
        endcase
      end
      MODE_WORD, MODE_NAME: begin
        if (winner >= 0) return color_argb[winner];
        for (int i = 0; i < NumNames; i++)
          if (alive[i] && color_names[i].len() == name_seen) return color_argb[i];
        return OpaqueBlack;
      end
      MODE_RGB_AFTER, MODE_RGB_BODY, MODE_RGB_DONE: begin
        if (pmode != MODE_RGB_DONE) begin
          if (num_open) close_number();
          // rgba cut short before its alpha and without ')'
          if (with_alpha && slot < LimitRgba) chan[CompAlpha] = 8'h00;
        end
        return {chan[CompAlpha], chan[CompRed], chan[CompGreen], chan[CompBlue]};
      end
      default: return OpaqueBlack;
    endcase
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) char_buf.push_back(s[k]);
  endtask

  task automatic add_tail();
    repeat ($urandom_range(1, 4)) char_buf.push_back(8'($urandom_range(32, 126)));
  endtask

  // Build one random string in char_buf: mostly well-formed, some noise and damage
  task automatic make_random_string();
    int    kind;
    int    n;
    int    k;
    int    v;
    string word;
    string hex_set;
    hex_set = "0123456789abcdefABCDEF";
    char_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 5);
        char_buf.push_back(k == 5 ? ChSpace : 8'(ChTab + k));
      end
    end
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      char_buf.push_back(ChHash);
      k = $urandom_range(0, 9);
      n = (k < 3) ? 3 : (k < 6) ? 6 : (k < 8) ? 8 : $urandom_range(0, 10);
      repeat (n) char_buf.push_back(hex_set[$urandom_range(0, 21)]);
      if ($urandom_range(0, 3) == 0) add_tail();
    end else if (kind < 60) begin
      if ($urandom_range(0, 1)) add_text("rgba");
      else add_text("rgb");
      if ($urandom_range(0, 5) != 0) add_text("(");
      n = $urandom_range(0, 5);
      for (k = 0; k < n; k++) begin
        if (k > 0)
          case ($urandom_range(0, 3))
            0: add_text(",");
            1: add_text(", ");
            2: add_text(" ");
            default: add_text(" / ");
          endcase
        v = (k == 3 && $urandom_range(0, 2) != 0) ? $urandom_range(0, 1) :
            ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 300);
        if (v != 0 || $urandom_range(0, 3) != 0) add_text($sformatf("%0d", v));
        if ($urandom_range(0, 1) == 0) begin
          char_buf.push_back(ChDot);
          repeat ($urandom_range(0, 6)) char_buf.push_back(8'(ChDigit0 + $urandom_range(0, 9)));
        end
      end
      if ($urandom_range(0, 4) != 0) char_buf.push_back(ChClose);
      if ($urandom_range(0, 4) == 0) add_tail();
    end else if (kind < 88) begin
      word = color_names[$urandom_range(0, NumNames - 1)];
      n = word.len();
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (k = 0; k < n; k++)
        char_buf.push_back($urandom_range(0, 1) ? (word[k] ^ 8'h20) : word[k]);
      case ($urandom_range(0, 3))
        0: add_tail();
        1: char_buf.push_back(8'($urandom_range(ChLowerA, ChLowerZ)));
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 12)) char_buf.push_back(8'($urandom_range(0, 255)));
    end
    // damage: a wrong byte, an early zero byte, or a cut
    if ($urandom_range(0, 9) == 0 && char_buf.size() > 0) begin
      k = $urandom_range(0, char_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: char_buf[k] = 8'($urandom_range(0, 255));
        1: char_buf[k] = ChNul;
        default: while (char_buf.size() > k) void'(char_buf.pop_back());
      endcase
    end
    if (char_buf.size() == 0) char_buf.push_back(ChNul);
  endtask

  // Offer char_buf as one string, last flag on its final byte
  task automatic send_chars(input logic [32:0] tag);
    int gap;
    known_colors.push_back(tag);
    for (int k = 0; k < char_buf.size(); k++) begin
      gap = quiet ? 0 : idle_len();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.char_byte <= char_buf[k];
      in_ch.last_char <= (k == char_buf.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
      chars_sent++;
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        out_ch.ready <= 1'b1;
        holds_done++;
      end else begin
        n = quiet ? 0 : idle_len();
        if (n == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Monitor: predict on each accepted character, check each accepted color
  always @(posedge clk) begin
    logic [32:0] tag;
    logic [31:0] want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (!string_ended) begin
          if (in_ch.char_byte == ChNul) string_ended = 1'b1;
          else parse_char(in_ch.char_byte);
        end
        if (in_ch.last_char) begin
          want = color_of_string();
          tag  = known_colors.pop_front();
          expected_colors.push_back(tag[32] ? tag[31:0] : want);
          clear_parser();
          strings_done++;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_colors.size() == 0) begin
          $error("argb_color: expected none, got %h", out_ch.argb_color);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          colors_seen++;
          if (out_ch.argb_color !== want) begin
            $error("argb_color: expected %h, got %h", want, out_ch.argb_color);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("css_color_string_parser_tb: done, errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    clear_parser();
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.last_char = 1'b0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_cases[i]) begin
      char_buf.delete();
      for (int k = 0; k < directed_cases[i].text.len(); k++) begin
        if (k == directed_cases[i].nul_at) char_buf.push_back(ChNul);
        char_buf.push_back(directed_cases[i].text[k]);
      end
      if (directed_cases[i].nul_at >= directed_cases[i].text.len()) char_buf.push_back(ChNul);
      send_chars({directed_cases[i].known, directed_cases[i].argb});
    end

    // random strings; one stretch runs under the long receiver hold-off
    for (int s = 0; random_chars < RandomChars; s++) begin
      quiet = (s >= 10 && s < 22) || (s >= 40 && s < 48);
      if (s == 10) hold_req = 1'b1;
      make_random_string();
      random_chars += char_buf.size();
      send_chars(33'h0);
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Parsed %0d strings from %0d characters; %0d colors compared, %0d long hold-off(s).",
             strings_done, chars_sent, colors_seen, holds_done);
    if (error_count == 0)
      $display("css_color_string_parser_tb: done, clean");
    else
      $display("css_color_string_parser_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
sv/ccsp_pkg.sv
sv/ccsp_in_if.sv
sv/ccsp_out_if.sv
sv/ccsp_name_match.sv
sv/ccsp_parse.sv
sv/ccsp_alpha_scale.sv
sv/css_color_string_parser.sv
sv/ccsp_checker.sv
sim/css_color_string_parser_tb.sv
